### hdl/pva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg
// Shared widths, codes, beat types and the CORDIC angle table for the polar
// vector ALU.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int CORDIC_STEPS = 16;   // 8 .. 32
  localparam int AMP_W        = 32;
  localparam int PH_W         = 16;
  localparam int FRAC         = 16;   // Q16.16 amplitude
  localparam int GUARD        = 16;   // extra CORDIC bits below the amplitude
  localparam int CW           = 64;   // CORDIC coordinate width
  localparam int ZW           = 34;   // rotation angle accumulator width
  localparam int OP_W         = 3;

  localparam int ROT_LAT  = CORDIC_STEPS + 1;
  localparam int VEC_LAT  = CORDIC_STEPS + 1;
  localparam int GAIN_LAT = 4;
  localparam int DIV_LAT  = AMP_W + 1;
  localparam int LAT      = ROT_LAT + 1 + VEC_LAT + GAIN_LAT + 1 + DIV_LAT + 1
                            + DIV_LAT + 1;

  localparam logic [31:0]      INV_GAIN = 32'd2608131496;
  localparam logic [AMP_W-1:0] AMP_MAX  = '1;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_BAL = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // atan(2^-i) as a 32-bit binary angle
  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [AMP_W-1:0] amp_a;
    logic [PH_W-1:0]  phase_a;
    logic [AMP_W-1:0] amp_b;
    logic [PH_W-1:0]  phase_b;
    logic [AMP_W-1:0] amp_w;
    logic [PH_W-1:0]  phase_w;
  } in_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp_out;
    logic [PH_W-1:0]  phase_out;
    logic [AMP_W-1:0] amp_corr;
    logic [PH_W-1:0]  phase_corr;
    logic [1:0]       status;
  } out_t;

endpackage
`default_nettype wire

### hdl/pva_rot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pva_rot
// Pipelined CORDIC rotation: polar amplitude/phase to x/y, one step a stage.
// ----------------------------------------------------------------------------
module pva_rot import pva_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [AMP_W-1:0] amp,
  input  logic [PH_W-1:0]  ph,
  output coord_t           x_out,
  output coord_t           y_out
);

  coord_t                x [0:CORDIC_STEPS];
  coord_t                y [0:CORDIC_STEPS];
  logic signed [ZW-1:0]  z [0:CORDIC_STEPS];

  logic        flip;
  logic [31:0] ang;
  coord_t      x_mag;

  // quadrants 1 and 2 are folded by negating x and turning half a circle
  assign flip  = (ph[PH_W-1:PH_W-2] == 2'd1) || (ph[PH_W-1:PH_W-2] == 2'd2);
  assign ang   = {ph[PH_W-1] ^ flip, ph[PH_W-2:0], 16'b0};
  assign x_mag = {{(CW-AMP_W-GUARD){1'b0}}, amp, {GUARD{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      x[0] <= flip ? -x_mag : x_mag;
      y[0] <= '0;
      z[0] <= {{(ZW-32){ang[31]}}, ang};
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!z[k][ZW-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - ZW'(ATAN_TAB[k]);
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + ZW'(ATAN_TAB[k]);
        end
      end
    end
  end

  assign x_out = x[CORDIC_STEPS];
  assign y_out = y[CORDIC_STEPS];

endmodule
`default_nettype wire

### hdl/pva_vec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pva_vec
// Pipelined CORDIC vectoring: x/y to scaled magnitude and binary angle.
// ----------------------------------------------------------------------------
module pva_vec import pva_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  coord_t      x_in,
  input  coord_t      y_in,
  output coord_t      x_out,
  output logic [31:0] z_out
);

  coord_t      x [0:CORDIC_STEPS];
  coord_t      y [0:CORDIC_STEPS];
  logic [31:0] z [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (x_in[CW-1]) begin
        x[0] <= -x_in;
        y[0] <= -y_in;
        z[0] <= 32'h8000_0000;
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic y_pos;
    assign y_pos = !y[k][CW-1] && (y[k] != '0);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (y_pos) begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + ATAN_TAB[k];
        end else begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - ATAN_TAB[k];
        end
      end
    end
  end

  assign x_out = x[CORDIC_STEPS];
  assign z_out = z[CORDIC_STEPS];

endmodule
`default_nettype wire

### hdl/pva_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pva_div
// Pipelined restoring divider for Q16.16: (n << 16) / d, one quotient bit a
// stage, saturating at all ones.
// ----------------------------------------------------------------------------
module pva_div import pva_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [AMP_W-1:0] n,
  input  logic [AMP_W-1:0] d,
  output logic [AMP_W-1:0] q_out,
  output logic             sat_out
);

  logic [AMP_W-1:0] rem [0:AMP_W];
  logic [AMP_W-1:0] nb  [0:AMP_W];
  logic [AMP_W-1:0] dv  [0:AMP_W];
  logic [AMP_W-1:0] q   [0:AMP_W];
  logic             sat [0:AMP_W];

  // quotient fits 32 bits only when the integer part of n is below d
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= {{(AMP_W-FRAC){1'b0}}, n[AMP_W-1:FRAC]};
      nb[0]  <= {n[FRAC-1:0], {(AMP_W-FRAC){1'b0}}};
      dv[0]  <= d;
      q[0]   <= '0;
      sat[0] <= {{(AMP_W-FRAC){1'b0}}, n[AMP_W-1:FRAC]} >= d;
    end
  end

  for (genvar k = 0; k < AMP_W; k++) begin : g_bit
    logic [AMP_W:0] t;
    logic [AMP_W:0] diff;
    logic           ge;
    assign t    = {rem[k], nb[k][AMP_W-1]};
    assign diff = t - {1'b0, dv[k]};
    assign ge   = t >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= ge ? diff[AMP_W-1:0] : t[AMP_W-1:0];
        nb[k+1]  <= {nb[k][AMP_W-2:0], 1'b0};
        dv[k+1]  <= dv[k];
        q[k+1]   <= {q[k][AMP_W-2:0], ge};
        sat[k+1] <= sat[k];
      end
    end
  end

  assign q_out   = sat[AMP_W] ? AMP_MAX : q[AMP_W];
  assign sat_out = sat[AMP_W];

endmodule
`default_nettype wire

### hdl/polar_vector_alu_with_balancing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polar_vector_alu_with_balancing
// Polar phasor ALU: add, subtract, multiply, divide and balance correction on
// Q16.16 amplitudes and 16-bit binary angles.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                         | beat
//  src      | in        | src_valid, src_stall, src_data  | in_t: op, A, B, W
//  res      | out       | res_valid, res_stall, res_data  | out_t: result, status
//
//  One beat per cycle in, one per cycle out while src_stall is low; the two
//  CORDIC pipelines and the two dividers lie in series. The whole pipe
//  advances together; src_stall rises only while a finished result waits at
//  res with res_stall high.
//  Reset clears the valid line only.
module polar_vector_alu_with_balancing import pva_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  in_t  src_data,
  output logic res_valid,
  input  logic res_stall,
  output out_t res_data
);

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [AMP_W-1:0] aa;
    logic [AMP_W-1:0] ab;
    logic [AMP_W-1:0] aw;
    logic [PH_W-1:0]  pa;
    logic [PH_W-1:0]  pb;
    logic [PH_W-1:0]  pw;
    logic             zero;
  } sa_t;

  typedef struct packed {
    sa_t              s;
    logic [63:0]      prod;
  } sb_t;

  typedef struct packed {
    sb_t              s;
    logic [AMP_W-1:0] samp;
    logic [PH_W-1:0]  sph;
    logic             ssat;
  } sd_t;

  typedef struct packed {
    logic [AMP_W-1:0] aa;
    logic [PH_W-1:0]  pa;
    logic [AMP_W-1:0] amp;
    logic [PH_W-1:0]  ph;
    logic [1:0]       st;
    logic             sat;
    logic             corr;
  } se_t;

  logic adv;
  logic vld [0:LAT-1];

  assign adv       = !res_valid || !res_stall;
  assign src_stall = !adv;
  assign res_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= src_valid;
    end
  end

  for (genvar k = 1; k < LAT; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // ---- rotate A and B to rectangular form
  coord_t xa, ya, xb, yb;
  sa_t    sa [0:ROT_LAT-1];

  pva_rot u_rot_a (.clk, .adv, .amp(src_data.amp_a), .ph(src_data.phase_a),
                   .x_out(xa), .y_out(ya));
  pva_rot u_rot_b (.clk, .adv, .amp(src_data.amp_b), .ph(src_data.phase_b),
                   .x_out(xb), .y_out(yb));

  always_ff @(posedge clk) begin
    if (adv) begin
      sa[0].op   <= src_data.op;
      sa[0].aa   <= src_data.amp_a;
      sa[0].ab   <= src_data.amp_b;
      sa[0].aw   <= src_data.amp_w;
      sa[0].pa   <= src_data.phase_a;
      sa[0].pb   <= src_data.phase_b;
      sa[0].pw   <= src_data.phase_w;
      sa[0].zero <= (src_data.amp_a == '0) || (src_data.amp_b == '0) ||
                    ((src_data.op == OP_BAL) && (src_data.amp_w == '0));
    end
  end

  for (genvar k = 1; k < ROT_LAT; k++) begin : g_sa
    always_ff @(posedge clk) begin
      if (adv) sa[k] <= sa[k-1];
    end
  end

  // ---- combine: vector sum or difference, and the amplitude product
  coord_t cx, cy;
  sb_t    sb [0:VEC_LAT];
  logic   neg_b;

  assign neg_b = (sa[ROT_LAT-1].op == OP_SUB) || (sa[ROT_LAT-1].op == OP_BAL);

  always_ff @(posedge clk) begin
    if (adv) begin
      cx         <= neg_b ? xa - xb : xa + xb;
      cy         <= neg_b ? ya - yb : ya + yb;
      sb[0].s    <= sa[ROT_LAT-1];
      sb[0].prod <= 64'(sa[ROT_LAT-1].aa) * 64'(sa[ROT_LAT-1].ab);
    end
  end

  for (genvar k = 1; k <= VEC_LAT; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (adv) sb[k] <= sb[k-1];
    end
  end

  // ---- back to polar
  coord_t      vx;
  logic [31:0] vz;

  pva_vec u_vec (.clk, .adv, .x_in(cx), .y_in(cy), .x_out(vx), .z_out(vz));

  // ---- remove the gain twice, each multiply split over two stages
  logic [63:0] m0;
  logic [63:0] p1, m2, p3, m4;
  logic [31:0] h1, h3;
  logic [31:0] zg [0:GAIN_LAT-1];
  sb_t         sg [0:GAIN_LAT-1];

  assign m0 = vx[CW-1] ? '0 : 64'(vx);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= 64'(m0[31:0]) * 64'(INV_GAIN);
      h1 <= m0[63:32];
      m2 <= 64'(h1) * 64'(INV_GAIN) + {32'b0, p1[63:32]};
      p3 <= 64'(m2[31:0]) * 64'(INV_GAIN);
      h3 <= m2[63:32];
      m4 <= 64'(h3) * 64'(INV_GAIN) + {32'b0, p3[63:32]};
      zg[0] <= vz;
      sg[0] <= sb[VEC_LAT];
    end
  end

  for (genvar k = 1; k < GAIN_LAT; k++) begin : g_sg
    always_ff @(posedge clk) begin
      if (adv) begin
        zg[k] <= zg[k-1];
        sg[k] <= sg[k-1];
      end
    end
  end

  // ---- round magnitude and angle
  logic [63:0] m5;
  logic [31:0] zr;
  sd_t         sd [0:DIV_LAT];

  assign m5 = (m4 + 64'h8000) >> GUARD;
  assign zr = zg[GAIN_LAT-1] + 32'h8000;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0].s <= sg[GAIN_LAT-1];
      if (m5 == '0) begin
        sd[0].samp <= '0;
        sd[0].sph  <= '0;
        sd[0].ssat <= 1'b0;
      end else begin
        sd[0].samp <= (m5[63:AMP_W] != '0) ? AMP_MAX : m5[AMP_W-1:0];
        sd[0].sph  <= zr[31:32-PH_W];
        sd[0].ssat <= m5[63:AMP_W] != '0;
      end
    end
  end

  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_sd
    always_ff @(posedge clk) begin
      if (adv) sd[k] <= sd[k-1];
    end
  end

  // ---- first divide: A/B, or difference over W in balance
  logic [AMP_W-1:0] q1;
  logic             q1_sat;
  logic [AMP_W-1:0] n1, d1;

  assign n1 = (sd[0].s.s.op == OP_BAL) ? sd[0].samp : sd[0].s.s.aa;
  assign d1 = (sd[0].s.s.op == OP_BAL) ? sd[0].s.s.aw : sd[0].s.s.ab;

  pva_div u_div1 (.clk, .adv, .n(n1), .d(d1), .q_out(q1), .sat_out(q1_sat));

  // ---- per-op result
  sd_t  r;
  se_t  e_next;
  se_t  se [0:DIV_LAT];

  assign r = sd[DIV_LAT];

  always_comb begin
    e_next     = '0;
    e_next.aa  = r.s.s.aa;
    e_next.pa  = r.s.s.pa;
    e_next.st  = ST_OK;
    if (r.s.s.op > OP_BAL) begin
      e_next.st = ST_BAD;
    end else if (r.s.s.zero) begin
      e_next.st = ST_ZERO;
    end else begin
      unique case (r.s.s.op)
        OP_ADD, OP_SUB: begin
          e_next.amp = r.samp;
          e_next.ph  = r.sph;
          e_next.sat = r.ssat;
        end
        OP_MUL: begin
          e_next.sat = r.s.prod[63:48] != '0;
          e_next.amp = e_next.sat ? AMP_MAX : r.s.prod[47:16];
          e_next.ph  = r.s.s.pa + r.s.s.pb;
        end
        OP_DIV: begin
          e_next.amp = q1;
          e_next.sat = q1_sat;
          e_next.ph  = r.s.s.pa - r.s.s.pb;
        end
        default: begin
          // balance: a zero-length influence leaves nothing to correct
          if (q1 == '0) begin
            e_next.st = ST_ZERO;
          end else begin
            e_next.amp  = q1;
            e_next.ph   = r.sph - r.s.s.pw;
            e_next.sat  = r.ssat | q1_sat;
            e_next.corr = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) se[0] <= e_next;
  end

  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_se
    always_ff @(posedge clk) begin
      if (adv) se[k] <= se[k-1];
    end
  end

  // ---- second divide: correction amplitude A over influence
  logic [AMP_W-1:0] q2;
  logic             q2_sat;

  pva_div u_div2 (.clk, .adv, .n(se[0].aa), .d(se[0].amp), .q_out(q2),
                  .sat_out(q2_sat));

  // ---- output register
  se_t  f;
  logic f_sat;

  assign f     = se[DIV_LAT];
  assign f_sat = f.sat | (f.corr & q2_sat);

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data.amp_out    <= f.amp;
      res_data.phase_out  <= f.ph;
      res_data.amp_corr   <= f.corr ? q2 : '0;
      res_data.phase_corr <= f.corr ? f.pa - f.ph : '0;
      res_data.status     <= ((f.st == ST_OK) && f_sat) ? ST_SAT : f.st;
    end
  end

endmodule
`default_nettype wire

### test/pva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_checker
// Watches both channels of the polar vector ALU, computes the result of each
// accepted input beat and compares every result beat, field by field, with
// the oldest one still waiting.
// ----------------------------------------------------------------------------
module pva_checker import pva_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  input  logic src_stall,
  input  in_t  src_data,
  input  logic res_valid,
  input  logic res_stall,
  input  out_t res_data,
  output int   errors,
  output int   pending
);

  out_t waiting_results[$];

  // polar to rectangular, coordinates carry GUARD extra fraction bits
  function automatic void polar_to_xy(input logic [31:0] amp, input logic [15:0] ph,
                                      output longint xo, output longint yo);
    longint x, y, z, nx, ny;
    logic [31:0] a;
    x = longint'({32'd0, amp}) <<< GUARD;
    y = 0;
    a = {ph, 16'h0};
    if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
      x = -x;
      a = a + 32'h8000_0000;
    end
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'({32'd0, ATAN_TAB[i]});
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += longint'({32'd0, ATAN_TAB[i]});
      end
      x = nx; y = ny;
    end
    xo = x; yo = y;
  endfunction

  function automatic logic [63:0] gain_trim(input logic [63:0] m);
    logic [63:0] hi, lo;
    hi = m >> 32;
    lo = {32'd0, m[31:0]};
    return hi * {32'd0, INV_GAIN} + ((lo * {32'd0, INV_GAIN}) >> 32);
  endfunction

  // vector sum (or difference); returns the saturation flag
  function automatic bit vector_sum(input logic [31:0] aa, input logic [15:0] pa,
                                    input logic [31:0] ab, input logic [15:0] pb,
                                    input bit sub, output logic [31:0] amp,
                                    output logic [15:0] ph);
    longint xa, ya, xb, yb, x, y, nx, ny;
    logic [31:0] z, t;
    logic [63:0] m;
    polar_to_xy(aa, pa, xa, ya);
    polar_to_xy(ab, pb, xb, yb);
    if (sub) begin
      xb = -xb; yb = -yb;
    end
    x = xa + xb; y = ya + yb;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    m = (x > 0) ? 64'(x) : 64'd0;
    m = gain_trim(gain_trim(m));
    m = (m + 64'(1 << (GUARD - 1))) >> GUARD;
    amp = 0; ph = 0;
    if (m == 0) return 0;
    t = z + 32'h8000;
    ph = t[31:16];
    if (m > {32'd0, AMP_MAX}) begin
      amp = AMP_MAX;
      return 1;
    end
    amp = m[31:0];
    return 0;
  endfunction

  function automatic logic [31:0] q_divide(input logic [31:0] n, input logic [31:0] d,
                                           inout bit sat);
    logic [63:0] q;
    if (d == 0) begin
      sat = 1;
      return AMP_MAX;
    end
    q = ({32'd0, n} << FRAC) / {32'd0, d};
    if (q > {32'd0, AMP_MAX}) begin
      sat = 1;
      return AMP_MAX;
    end
    return q[31:0];
  endfunction

  function automatic out_t polar_result(input in_t b);
    out_t r;
    bit sat;
    logic [63:0] p;
    logic [31:0] damp;
    logic [15:0] dph;
    r = '0;
    sat = 0;
    r.status = ST_OK;
    if (b.op > OP_BAL) begin
      r.status = ST_BAD;
    end else if (b.amp_a == 0 || b.amp_b == 0 || (b.op == OP_BAL && b.amp_w == 0)) begin
      r.status = ST_ZERO;
    end else if (b.op == OP_ADD || b.op == OP_SUB) begin
      sat = vector_sum(b.amp_a, b.phase_a, b.amp_b, b.phase_b, b.op == OP_SUB,
                       r.amp_out, r.phase_out);
    end else if (b.op == OP_MUL) begin
      p = ({32'd0, b.amp_a} * {32'd0, b.amp_b}) >> FRAC;
      if (p > {32'd0, AMP_MAX}) begin
        sat = 1;
        r.amp_out = AMP_MAX;
      end else begin
        r.amp_out = p[31:0];
      end
      r.phase_out = b.phase_a + b.phase_b;
    end else if (b.op == OP_DIV) begin
      r.amp_out = q_divide(b.amp_a, b.amp_b, sat);
      r.phase_out = b.phase_a - b.phase_b;
    end else begin
      sat = vector_sum(b.amp_a, b.phase_a, b.amp_b, b.phase_b, 1, damp, dph);
      r.amp_out = q_divide(damp, b.amp_w, sat);
      r.phase_out = dph - b.phase_w;
      if (r.amp_out == 0) begin
        // influence vanished: nothing to correct
        r.status = ST_ZERO;
        r.phase_out = 0;
        sat = 0;
      end else begin
        r.amp_corr = q_divide(b.amp_a, r.amp_out, sat);
        r.phase_corr = b.phase_a - r.phase_out;
      end
    end
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst) begin
      if (src_valid && !src_stall) waiting_results.push_back(polar_result(src_data));
      if (res_valid && !res_stall) begin
        if (waiting_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = waiting_results.pop_front();
          if (res_data.amp_out !== e.amp_out) begin
            $error("amp_out: expected %h, got %h", e.amp_out, res_data.amp_out);
            errors++;
          end
          if (res_data.phase_out !== e.phase_out) begin
            $error("phase_out: expected %h, got %h", e.phase_out, res_data.phase_out);
            errors++;
          end
          if (res_data.amp_corr !== e.amp_corr) begin
            $error("amp_corr: expected %h, got %h", e.amp_corr, res_data.amp_corr);
            errors++;
          end
          if (res_data.phase_corr !== e.phase_corr) begin
            $error("phase_corr: expected %h, got %h", e.phase_corr, res_data.phase_corr);
            errors++;
          end
          if (res_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, res_data.status);
            errors++;
          end
        end
      end
      pending = waiting_results.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random phasor beats into the polar vector ALU, stalls
// the result side at random and once for a long stretch, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
  import pva_pkg::*;

  localparam int N_RANDOM    = 1950;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic src_valid = 0;
  logic src_stall;
  in_t  src_data = '0;
  logic res_valid;
  logic res_stall = 0;
  out_t res_data;
  int   errors, pending;
  int   cycles = 0;

  always #6 clk = ~clk;

  polar_vector_alu_with_balancing u_top (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  pva_checker u_checker (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, and a quiet window
  initial begin
    int n;
    n = 0;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n > 600 && n < 1000) res_stall = 1;
      else if (n > 1200 && n < 1600) res_stall = 0;
      else res_stall = ($urandom_range(99) < 10);
      n++;
      @(negedge clk);
    end
  end

  task automatic send_beat(input in_t b, input bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 10) begin
        src_valid = 0;
        @(negedge clk);
      end
    end
    src_valid = 1;
    src_data = b;
    do @(posedge clk); while (src_stall);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_amp();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(32'h0002_0000);
      5, 6:    return 32'h0001_0000 + $urandom_range(32'h0000_FFFF);
      7:       return 32'hFFFF_0000 | $urandom_range(32'hFFFF);
      8:       return $urandom_range(32'hFF);
      default: return ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(32'h00FF_FFFF);
    endcase
  endfunction

  function automatic in_t random_beat();
    in_t b;
    b.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    b.amp_a = pick_amp();
    b.phase_a = 16'($urandom);
    b.amp_b = pick_amp();
    b.phase_b = 16'($urandom);
    b.amp_w = pick_amp();
    b.phase_w = 16'($urandom);
    // occasionally equal vectors so differences cancel
    if ($urandom_range(15) == 0) begin
      b.amp_b = b.amp_a;
      b.phase_b = b.phase_a;
    end
    return b;
  endfunction

  function automatic in_t mk(input logic [2:0] op, input logic [31:0] aa,
                             input logic [15:0] pa, input logic [31:0] ab,
                             input logic [15:0] pb, input logic [31:0] aw,
                             input logic [15:0] pw);
    in_t b;
    b.op = op; b.amp_a = aa; b.phase_a = pa; b.amp_b = ab;
    b.phase_b = pb; b.amp_w = aw; b.phase_w = pw;
    return b;
  endfunction

  initial begin
    in_t directed[$];
    directed.push_back(mk(OP_ADD, 32'h0001_0000, 16'h0000, 32'h0001_0000, 16'h4000, 0, 0));
    directed.push_back(mk(OP_SUB, 32'h0003_0000, 16'h1234, 32'h0003_0000, 16'h1234, 0, 0));
    directed.push_back(mk(OP_ADD, '1, 16'h0000, '1, 16'h0000, 0, 0));
    directed.push_back(mk(OP_ADD, 32'h0002_0000, 16'h8000, 32'h0001_0000, 16'hC000, 1, 1));
    directed.push_back(mk(OP_SUB, '1, 16'hFFFF, '1, 16'h7FFF, '1, '1));
    directed.push_back(mk(OP_MUL, '1, 16'hFFFF, '1, 16'hFFFF, 0, 0));
    directed.push_back(mk(OP_MUL, 32'h0002_8000, 16'h4000, 32'h0000_8000, 16'hC000, 0, 0));
    directed.push_back(mk(OP_DIV, '1, 16'h0000, 32'd1, 16'hFFFF, 0, 0));
    directed.push_back(mk(OP_DIV, 32'h0006_0000, 16'h1000, 32'h0002_0000, 16'h3000, 0, 0));
    directed.push_back(mk(OP_BAL, 32'h0005_0000, 16'h2000, 32'h0002_0000, 16'h6000,
                          32'h0001_0000, 16'h1000));
    directed.push_back(mk(OP_BAL, 32'h0005_0000, 16'h2000, 32'h0005_0000, 16'h2000,
                          32'h0001_0000, 16'h1000));
    directed.push_back(mk(OP_BAL, 32'h0005_0000, 16'h2000, 32'h0002_0000, 16'h6000,
                          0, 16'h1000));
    directed.push_back(mk(OP_BAL, 32'h0000_0002, 16'h0000, 32'h0000_0001, 16'h0000,
                          '1, 16'hFFFF));
    directed.push_back(mk(OP_BAL, '1, 16'hFFFF, 32'd1, 16'h8000, 32'd1, 16'h0000));
    directed.push_back(mk(OP_ADD, 0, 16'h1111, 32'h0001_0000, 0, 0, 0));
    directed.push_back(mk(OP_MUL, 32'h0001_0000, 0, 0, 16'h2222, 0, 0));
    directed.push_back(mk(OP_DIV, 32'h0001_0000, 0, 0, 0, 0, 0));
    directed.push_back(mk(3'd5, 32'h0001_0000, 16'h1000, 32'h0001_0000, 0, 1, 0));
    directed.push_back(mk(3'd6, '1, '1, '1, '1, '1, '1));
    directed.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_ADD, 32'd1, 16'h4000, 32'd1, 16'hC000, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (directed[i]) send_beat(directed[i], 1);
    for (int i = 0; i < N_RANDOM; i++) send_beat(random_beat(), !(i > 900 && i < 1200));
    src_valid = 0;

    while (pending != 0) @(negedge clk);
    repeat (LAT + 20) @(negedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

### filelist.f
hdl/pva_pkg.sv
hdl/pva_rot.sv
hdl/pva_vec.sv
hdl/pva_div.sv
hdl/polar_vector_alu_with_balancing.sv
test/pva_checker.sv
test/tb_top.sv
